// ===== src/quaternion_to_euler_angles_assert.svh =====
// ============================================================================
// quaternion_to_euler_angles assertion macros
// concurrent assertion forms for the block's top module
// ============================================================================
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// same-cycle implication
`define QTE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/qte_pkg.sv =====
// ============================================================================
// qte_pkg
// types, constants and helper functions of the quaternion to euler block
// ============================================================================
package qte_pkg;

   localparam int SUM_W  = 33;   // saturated product sums, scale 2^-30
   localparam int CX_W   = 36;   // cordic x/y datapath
   localparam int CZ_W   = 34;   // cordic angle accumulator, scale 2^-29
   localparam int ANG_W  = 19;   // rounded angle before saturation
   localparam int RAD_W  = 61;   // sqrt radicand
   localparam int ROOT_W = 31;   // sqrt result
   localparam int SQRT_STAGES = 31;

   localparam logic signed [34:0] SUM_MAX = 35'sd4294967295;
   localparam logic signed [34:0] SUM_MIN = -35'sd4294967296;
   localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;
   localparam logic signed [CZ_W-1:0] PI_Q29 = 34'sd1686629713;
   localparam logic signed [ANG_W-1:0] PI_Q13 = 19'sd25736;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 19'sd12868;
   localparam logic [RAD_W-1:0] ONE_Q60 = 61'h1000_0000_0000_0000;

   typedef struct packed {
      logic signed [SUM_W-1:0] sr;
      logic signed [SUM_W-1:0] cr;
      logic signed [SUM_W-1:0] sp;
      logic signed [SUM_W-1:0] sy;
      logic signed [SUM_W-1:0] cy;
      logic                    clamp;
   } side_type;

   typedef struct packed {
      logic clamp;
      logic pos;
   } flag_type;

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [34:0] v);
      logic signed [34:0] r;
      r = v;
      if (v > SUM_MAX) r = SUM_MAX;
      else if (v < SUM_MIN) r = SUM_MIN;
      return r[SUM_W-1:0];
   endfunction

   function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [ANG_W-1:0] v,
                                                         input logic signed [ANG_W-1:0] lim);
      logic signed [ANG_W-1:0] r;
      r = v;
      if (v > lim) r = lim;
      else if (v < -lim) r = -lim;
      return r;
   endfunction

   // atan(2^-i) at scale 2^-29, rounded to nearest
   function automatic logic signed [CZ_W-1:0] atan_entry(input int unsigned i);
      logic [31:0] t;
      unique case (i)
         0: t = 32'd421657428;
         1: t = 32'd248918915;
         2: t = 32'd131521918;
         3: t = 32'd66762579;
         4: t = 32'd33510843;
         5: t = 32'd16771758;
         6: t = 32'd8387925;
         7: t = 32'd4194219;
         8: t = 32'd2097141;
         9: t = 32'd1048575;
         10: t = 32'd524288;
         11: t = 32'd262144;
         12: t = 32'd131072;
         13: t = 32'd65536;
         14: t = 32'd32768;
         15: t = 32'd16384;
         16: t = 32'd8192;
         17: t = 32'd4096;
         18: t = 32'd2048;
         19: t = 32'd1024;
         20: t = 32'd512;
         21: t = 32'd256;
         22: t = 32'd128;
         23: t = 32'd64;
         default: t = 32'd0;
      endcase
      return $signed({2'b00, t});
   endfunction

endpackage

// ===== src/quaternion_to_euler_angles.sv =====
// ============================================================================
// quaternion_to_euler_angles
// orientation quaternion to roll, pitch and yaw, fully pipelined
// ============================================================================
// one request on req_* carries a Q1.15 quaternion (w, x, y, z); one response
// on rsp_* returns roll and yaw in Q3.13 (range +-pi), pitch in Q2.13
// (range +-pi/2) and a flag set when the pitch argument reached plus or minus one
// both channels are valid/ready; a request is taken when req_valid and
// req_ready are high at a clock edge, likewise for rsp
// throughput: one request per cycle, sustained while no response waits unaccepted
// stages, in order: products, saturated sums, sine square, 31 square root
//   stages, then cordic fold, CORDIC_STAGES rotations, rounding and the
//   output register
// the square root of the pitch cosine sets most of that depth
// all stages move together; while a response waits unaccepted the whole
// pipe holds and req_ready drops, so nothing is lost or repeated
// synchronous reset clears every valid bit; payload registers are not reset
// the block keeps no state between requests
// ============================================================================
module quaternion_to_euler_angles #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic               rsp_pitch_clamped
);

`include "quaternion_to_euler_angles_assert.svh"

   localparam int NSQ  = qte_pkg::SQRT_STAGES;
   localparam int NFL  = CORDIC_STAGES + 2;
   localparam int AW   = qte_pkg::ANG_W;

   // global advance: the output slot is free or being taken
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 1: the nine products, exact at 2^-30
   logic               v1_ff;
   logic signed [31:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_zz_ff;
   logic signed [31:0] p_wy_ff, p_zx_ff, p_wz_ff, p_xy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_wx_ff <= req_quat_w * req_quat_x;
         p_yz_ff <= req_quat_y * req_quat_z;
         p_xx_ff <= req_quat_x * req_quat_x;
         p_yy_ff <= req_quat_y * req_quat_y;
         p_zz_ff <= req_quat_z * req_quat_z;
         p_wy_ff <= req_quat_w * req_quat_y;
         p_zx_ff <= req_quat_z * req_quat_x;
         p_wz_ff <= req_quat_w * req_quat_z;
         p_xy_ff <= req_quat_x * req_quat_y;
      end
   end

   // stage 2: doubled sums, saturated to 33 bits
   logic                side2_valid_ff;
   qte_pkg::side_type   side2_ff;
   qte_pkg::side_type   side2_in;

   always_comb begin
      side2_in.sr = qte_pkg::sat_sum((35'(p_wx_ff) + 35'(p_yz_ff)) <<< 1);
      side2_in.cr = qte_pkg::sat_sum(qte_pkg::ONE_Q30 - ((35'(p_xx_ff) + 35'(p_yy_ff)) <<< 1));
      side2_in.sp = qte_pkg::sat_sum((35'(p_wy_ff) - 35'(p_zx_ff)) <<< 1);
      side2_in.sy = qte_pkg::sat_sum((35'(p_wz_ff) + 35'(p_xy_ff)) <<< 1);
      side2_in.cy = qte_pkg::sat_sum(qte_pkg::ONE_Q30 - ((35'(p_yy_ff) + 35'(p_zz_ff)) <<< 1));
      side2_in.clamp = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side2_valid_ff <= 1'b0;
      end else if (en) begin
         side2_valid_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side2_in;
      end
   end

   // stage 3: clamp test and radicand 1 - s^2 at 2^-60
   logic                          v3_ff;
   qte_pkg::side_type             side3_ff;
   qte_pkg::side_type             side3_in;
   logic [qte_pkg::RAD_W-1:0]     rad3_ff;
   logic [qte_pkg::RAD_W-1:0]     rad3_in;
   logic signed [30:0]            sp_n;
   logic signed [61:0]            sp_sq;
   logic                          clamp3;

   always_comb begin
      clamp3 = (side2_ff.sp >= 33'sd1073741824) || (side2_ff.sp <= -33'sd1073741824);
      sp_n   = clamp3 ? '0 : $signed(side2_ff.sp[30:0]);
      sp_sq  = sp_n * sp_n;
      rad3_in = qte_pkg::ONE_Q60 - sp_sq[qte_pkg::RAD_W-1:0];
      side3_in = side2_ff;
      side3_in.clamp = clamp3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= side2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff <= side3_in;
         rad3_ff  <= rad3_in;
      end
   end

   // square root for the pitch cosine; sums ride alongside
   logic                           sq_valid;
   logic [qte_pkg::ROOT_W-1:0]     sq_root;
   qte_pkg::side_type              side_ff [NSQ];

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_value  (rad3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side3_ff;
         for (int k = 1; k < NSQ; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // three arctangent pipes in lockstep
   qte_pkg::side_type           side_sq;
   logic signed [qte_pkg::SUM_W-1:0] pitch_x;
   logic                        crd_valid;
   logic                        crd_valid_p;
   logic                        crd_valid_y;
   logic signed [AW-1:0]        roll_raw, pitch_raw, yaw_raw;

   assign side_sq = side_ff[NSQ-1];
   assign pitch_x = $signed({2'b00, sq_root});

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_y      (side_sq.sr),
      .in_x      (side_sq.cr),
      .out_valid (crd_valid),
      .out_angle (roll_raw)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_y      (side_sq.sp),
      .in_x      (pitch_x),
      .out_valid (crd_valid_p),
      .out_angle (pitch_raw)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_y      (side_sq.sy),
      .in_x      (side_sq.cy),
      .out_valid (crd_valid_y),
      .out_angle (yaw_raw)
   );

   // pitch clamp flag delayed to meet the cordic outputs
   qte_pkg::flag_type flag_ff [NFL];

   always_ff @(posedge clock) begin
      if (en) begin
         flag_ff[0].clamp <= side_sq.clamp;
         flag_ff[0].pos   <= side_sq.sp > 0;
         for (int k = 1; k < NFL; k++) begin
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   // output register: saturate, apply pitch clamp
   logic                 rsp_valid_ff;
   logic signed [15:0]   roll_ff, yaw_ff;
   logic signed [14:0]   pitch_ff;
   logic                 clamped_ff;
   logic signed [AW-1:0] roll_in, yaw_in, pitch_in;

   always_comb begin
      roll_in = qte_pkg::sat_angle(roll_raw, qte_pkg::PI_Q13);
      yaw_in  = qte_pkg::sat_angle(yaw_raw, qte_pkg::PI_Q13);
      if (flag_ff[NFL-1].clamp) begin
         pitch_in = flag_ff[NFL-1].pos ? qte_pkg::HALF_PI_Q13 : -qte_pkg::HALF_PI_Q13;
      end else begin
         pitch_in = qte_pkg::sat_angle(pitch_raw, qte_pkg::HALF_PI_Q13);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= crd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff    <= roll_in[15:0];
         yaw_ff     <= yaw_in[15:0];
         pitch_ff   <= pitch_in[14:0];
         clamped_ff <= flag_ff[NFL-1].clamp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_pitch_clamped = clamped_ff;

   // the three cordic pipes stay in step
   `QTE_ASSERT_NOW(a_cordic_lockstep, clock, reset, 1'b1, (crd_valid == crd_valid_p) && (crd_valid == crd_valid_y), "cordic valid bits diverged")
   // a held pipe keeps its valid bits
   `QTE_ASSERT_NEXT(a_hold_when_stalled, clock, reset, !en, $stable(crd_valid), "pipe moved while stalled")
   // a clamped pitch is exactly plus or minus pi/2
   `QTE_ASSERT_NOW(a_clamp_value, clock, reset, rsp_valid_ff && clamped_ff, (pitch_ff == 15'sd12868) || (pitch_ff == -15'sd12868), "clamped pitch not at pi/2")
   // roll and yaw stay within plus or minus pi
   `QTE_ASSERT_NOW(a_angle_range, clock, reset, rsp_valid_ff, (roll_ff <= 16'sd25736) && (roll_ff >= -16'sd25736) && (yaw_ff <= 16'sd25736) && (yaw_ff >= -16'sd25736), "roll or yaw out of range")

endmodule

// ===== src/qte_isqrt.sv =====
// ============================================================================
// qte_isqrt
// pipelined integer square root, one result bit per stage
// ============================================================================
module qte_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [qte_pkg::RAD_W-1:0]      in_value,
   output logic                           out_valid,
   output logic [qte_pkg::ROOT_W-1:0]     out_root
);

   localparam int N = qte_pkg::SQRT_STAGES;
   localparam int W = qte_pkg::RAD_W;

   logic [W-1:0] rem_ff [N];
   logic [W-1:0] res_ff [N];
   logic         valid_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [W-1:0] rem_cur;
      logic [W-1:0] res_cur;
      logic         vld_cur;
      logic [W:0]   trial;
      logic [W-1:0] rem_in;
      logic [W-1:0] res_in;
      localparam logic [W-1:0] BIT = W'(1) << (W - 1 - 2 * k);

      if (k == 0) begin : g_first
         assign rem_cur = in_value;
         assign res_cur = '0;
         assign vld_cur = in_valid;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign res_cur = res_ff[k-1];
         assign vld_cur = valid_ff[k-1];
      end

      always_comb begin
         trial = {1'b0, res_cur} + {1'b0, BIT};
         if ({1'b0, rem_cur} >= trial) begin
            rem_in = rem_cur - trial[W-1:0];
            res_in = (res_cur >> 1) + BIT;
         end else begin
            rem_in = rem_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = res_ff[N-1][qte_pkg::ROOT_W-1:0];

endmodule

// ===== src/qte_cordic.sv =====
// ============================================================================
// qte_cordic
// pipelined four-quadrant arctangent by cordic vectoring
// ============================================================================
module qte_cordic #(
   parameter int STAGES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [qte_pkg::SUM_W-1:0]     in_y,
   input  logic signed [qte_pkg::SUM_W-1:0]     in_x,
   output logic                                 out_valid,
   output logic signed [qte_pkg::ANG_W-1:0]     out_angle
);

   localparam int XW = qte_pkg::CX_W;
   localparam int ZW = qte_pkg::CZ_W;

   logic signed [XW-1:0] x_ff [STAGES+1];
   logic signed [XW-1:0] y_ff [STAGES+1];
   logic signed [ZW-1:0] z_ff [STAGES+1];
   logic                 zero_ff [STAGES+1];
   logic                 valid_ff [STAGES+1];
   logic                 out_valid_ff;
   logic signed [qte_pkg::ANG_W-1:0] angle_ff;

   // prep: fold left half plane by a half turn
   logic signed [XW-1:0] px_in, py_in;
   logic signed [ZW-1:0] pz_in;
   always_comb begin
      px_in = XW'(in_x);
      py_in = XW'(in_y);
      pz_in = '0;
      if (in_x < 0) begin
         px_in = -XW'(in_x);
         py_in = -XW'(in_y);
         pz_in = (in_y >= 0) ? qte_pkg::PI_Q29 : -qte_pkg::PI_Q29;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= px_in;
         y_ff[0]    <= py_in;
         z_ff[0]    <= pz_in;
         zero_ff[0] <= (in_x == 0) && (in_y == 0);
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      logic signed [XW-1:0] xs, ys;
      logic signed [ZW-1:0] tab;
      assign xs  = x_ff[i] >>> i;
      assign ys  = y_ff[i] >>> i;
      assign tab = qte_pkg::atan_entry(i);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + tab;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - tab;
            end
         end
      end
   end

   // round half up from 2^-29 to 2^-13
   logic signed [ZW:0] zr;
   logic signed [ZW:0] zs;
   assign zr = (ZW+1)'(z_ff[STAGES]) + (ZW+1)'(32768);
   assign zs = zr >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= zero_ff[STAGES] ? '0 : zs[qte_pkg::ANG_W-1:0];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = angle_ff;

endmodule

// ===== bench/quaternion_to_euler_angles_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// quaternion_to_euler_angles_checker
// watches both channels, predicts euler angles per request and compares
// ============================================================================
module quaternion_to_euler_angles_checker #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_roll_angle,
   input  logic signed [14:0] rsp_pitch_angle,
   input  logic signed [15:0] rsp_yaw_angle,
   input  logic               rsp_pitch_clamped,
   output int                 fail_count,
   output int                 angles_pending
);

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               clamped;
   } euler_type;

   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint SUM_HI      = 64'sd4294967295;
   localparam longint SUM_LO      = -64'sd4294967296;
   localparam longint PI_Z        = 64'sd1686629713;
   localparam longint PI_ANG      = 64'sd25736;
   localparam longint HALF_PI_ANG = 64'sd12868;

   localparam longint ARCTAN [24] = '{
      421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
      8387925, 4194219, 2097141, 1048575, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096,
      2048, 1024, 512, 256, 128, 64};

   euler_type expected_angles[$];

   function automatic longint clip_sum(input longint v);
      if (v > SUM_HI) return SUM_HI;
      if (v < SUM_LO) return SUM_LO;
      return v;
   endfunction

   function automatic longint floor_root(input longint unsigned v);
      longint unsigned res, bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= res + bit_val) begin
            v = v - (res + bit_val);
            res = (res >> 1) + bit_val;
         end else begin
            res = res >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return longint'(res);
   endfunction

   // vectoring arctangent, q3.13 result clipped to +-lim
   function automatic longint vector_angle(input longint sy, input longint sx,
                                           input longint lim);
      longint ang, xs, ys, r;
      ang = 0;
      if (sx == 0 && sy == 0) return 0;
      if (sx < 0) begin
         sx = -sx;
         sy = -sy;
         ang = (sy <= 0) ? PI_Z : -PI_Z;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         xs = sx >>> i;
         ys = sy >>> i;
         if (sy >= 0) begin
            sx = sx + ys;
            sy = sy - xs;
            ang = ang + ARCTAN[i];
         end else begin
            sx = sx - ys;
            sy = sy + xs;
            ang = ang - ARCTAN[i];
         end
      end
      r = (ang + 32768) >>> 16;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic euler_type predict_angles(input longint w, input longint x,
                                                input longint y, input longint z);
      euler_type e;
      longint sr, cr, sp, sy, cy, c;
      sr = clip_sum(2 * (w * x + y * z));
      cr = clip_sum(ONE_Q30 - 2 * (x * x + y * y));
      sp = clip_sum(2 * (w * y - z * x));
      sy = clip_sum(2 * (w * z + x * y));
      cy = clip_sum(ONE_Q30 - 2 * (y * y + z * z));
      e.roll = 16'(vector_angle(sr, cr, PI_ANG));
      e.yaw  = 16'(vector_angle(sy, cy, PI_ANG));
      if (sp >= ONE_Q30 || sp <= -ONE_Q30) begin
         e.pitch   = 15'((sp > 0) ? HALF_PI_ANG : -HALF_PI_ANG);
         e.clamped = 1'b1;
      end else begin
         c = floor_root((64'd1 << 60) - longint'(sp * sp));
         e.pitch   = 15'(vector_angle(sp, c, HALF_PI_ANG));
         e.clamped = 1'b0;
      end
      return e;
   endfunction

   assign angles_pending = expected_angles.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      euler_type exp_e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_angles.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected response: roll %0d pitch %0d yaw %0d clamp %0b",
                           rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle,
                           rsp_pitch_clamped);
            end else begin
               exp_e = expected_angles.pop_front();
               if (rsp_roll_angle !== exp_e.roll || rsp_pitch_angle !== exp_e.pitch ||
                   rsp_yaw_angle !== exp_e.yaw || rsp_pitch_clamped !== exp_e.clamped)
               begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: exp r %0d p %0d y %0d c %0b, got r %0d p %0d y %0d c %0b",
                              exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.clamped,
                              rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle,
                              rsp_pitch_clamped);
               end
            end
         end
         // append at the tail so responses are matched in request order
         if (req_valid && req_ready)
            expected_angles.insert(expected_angles.size(),
                                   predict_angles(req_quat_w, req_quat_x,
                                                  req_quat_y, req_quat_z));
      end
   end

endmodule

// ===== bench/quaternion_to_euler_angles_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// quaternion_to_euler_angles_test
// drives quaternions with random gaps and stalls, checker verifies angles
// ============================================================================
module quaternion_to_euler_angles_test;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_quat_w = '0;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_roll_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic signed [15:0] rsp_yaw_angle;
   logic               rsp_pitch_clamped;
   int                 fail_count;
   int                 angles_pending;
   bit                 quiet_phase = 1'b0;   // no idling near the end
   int                 request_count = 0;
   int                 clamp_count = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quaternion_to_euler_angles dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_quat_w, .req_quat_x, .req_quat_y, .req_quat_z,
      .rsp_valid, .rsp_ready,
      .rsp_roll_angle, .rsp_pitch_angle, .rsp_yaw_angle, .rsp_pitch_clamped);

   quaternion_to_euler_angles_checker checker_i (
      .clock, .reset, .req_valid, .req_ready,
      .req_quat_w, .req_quat_x, .req_quat_y, .req_quat_z,
      .rsp_valid, .rsp_ready,
      .rsp_roll_angle, .rsp_pitch_angle, .rsp_yaw_angle, .rsp_pitch_clamped,
      .fail_count, .angles_pending);

   // response side: stall bursts, or long ready stretches
   always @(negedge clock) begin
      if (reset || quiet_phase || $urandom_range(3) != 0) begin
         rsp_ready = 1'b1;
         if (!reset && !quiet_phase) repeat ($urandom_range(20)) @(negedge clock);
      end else begin
         rsp_ready = 1'b0;
         repeat ($urandom_range(9)) @(negedge clock);
      end
   end

   // one request, entered and left at a falling edge
   task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] z);
      // optional gap before the request
      if (!quiet_phase && $urandom_range(4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_quat_w = w;
      req_quat_x = x;
      req_quat_y = y;
      req_quat_z = z;
      req_valid  = 1'b1;
      // hold until taken
      do @(posedge clock); while (!req_ready);
      request_count++;
      if (((longint'($signed(w)) * $signed(y) - longint'($signed(z)) * $signed(x)) * 2)
          >= 64'sd1073741824 ||
          ((longint'($signed(w)) * $signed(y) - longint'($signed(z)) * $signed(x)) * 2)
          <= -64'sd1073741824)
         clamp_count++;
      @(negedge clock);
   endtask

   // near-unit quaternion with random direction, loosely normalized
   task automatic send_rotation();
      int a, b, c, d;
      a = $urandom_range(32767);
      b = $urandom_range(32767 - a / 2);
      c = $urandom_range(16000);
      d = $urandom_range(12000);
      send_quat($urandom_range(1) ? 16'(a) : -16'(a), $urandom_range(1) ? 16'(b) : -16'(b),
                $urandom_range(1) ? 16'(c) : -16'(c), $urandom_range(1) ? 16'(d) : -16'(d));
   endtask

   initial begin
      int kind;
      int sgn;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zeros, identity, extremes, gimbal lock both ways, pi turns
      send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
      send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
      send_quat(16'sd23170, 16'sd0, 16'sd23170, 16'sd0);
      send_quat(16'sd23170, 16'sd0, -16'sd23170, 16'sd0);
      send_quat(16'sd23171, 16'sd1, 16'sd23171, -16'sd1);
      send_quat(16'sd23169, 16'sd0, 16'sd23169, 16'sd0);
      send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
      send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd0);
      send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
      send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768);
      send_quat(16'sd1, 16'sd32767, 16'sd0, 16'sd0);
      send_quat(-16'sd1, 16'sd32767, 16'sd0, 16'sd0);
      send_quat(16'sd0, 16'sd23170, 16'sd23170, 16'sd0);
      send_quat(16'sd0, 16'sd0, 16'sd23170, 16'sd23170);
      send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
      send_quat(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
      send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);

      // random mix: near-unit rotations, near-gimbal, tiny values, full-range noise
      for (int n = 0; n < 500; n++) begin
         if (n == 430) quiet_phase = 1'b1;
         kind = $urandom_range(9);
         sgn  = $urandom_range(1) ? 1 : -1;
         if (kind < 5) begin
            send_rotation();
         end else if (kind < 7) begin
            send_quat(16'(23170 + $urandom_range(40) - 20),
                      16'($urandom_range(64) - 32),
                      16'(sgn * (23170 + $urandom_range(40) - 20)),
                      16'($urandom_range(64) - 32));
         end else if (kind < 8) begin
            send_quat(16'($urandom_range(31) - 16), 16'($urandom_range(31) - 16),
                      16'($urandom_range(31) - 16), 16'($urandom_range(31) - 16));
         end else begin
            send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end
      end
      req_valid = 1'b0;

      // drain, then allow the pipeline latency to pass
      while (angles_pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("covered %0d quaternions, %0d with pitch at the clamp, under random gaps",
               request_count, clamp_count);
      $display("and response stalls; %0d mismatches, %0d responses left over",
               fail_count, angles_pending);
      if (fail_count == 0 && angles_pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== quaternion_to_euler_angles.f =====
+incdir+src
src/qte_pkg.sv
src/qte_isqrt.sv
src/qte_cordic.sv
src/quaternion_to_euler_angles.sv
bench/quaternion_to_euler_angles_checker.sv
bench/quaternion_to_euler_angles_test.sv
